// ----- rtl/calendar_date_adder_unit_macros.svh -----
// Assertion helpers for the calendar date adder.
// Each macro runs on the rising edge of clock and is off while reset is high.
`ifndef CALENDAR_DATE_ADDER_UNIT_MACROS_SVH
`define CALENDAR_DATE_ADDER_UNIT_MACROS_SVH

// Property that must hold at every edge.
`define CDA_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cda_pkg.sv -----
`timescale 1ns / 1ps

package cda_pkg;

   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [3:0]  MONTH_JAN   = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_DEC   = 4'd12;
   localparam logic [4:0]  DAY_FIRST   = 5'd1;
   localparam logic [4:0]  DAY_DEC_END = 5'd31;
   localparam logic [6:0]  CENT_WRAP   = 7'd99;
   localparam logic [13:0] CENT_YEARS  = 14'd100;

   // floor(y / 100) == (y * 5243) >> 19 for every y below 43699
   localparam logic [26:0] DIV100_MULT  = 27'd5243;
   localparam int          DIV100_SHIFT = 19;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_DIV,
      ST_LOAD_FIN,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept_load;
      logic accept_add;
      logic load_div;
      logic load_fin;
      logic walk;
      logic rsp_valid;
      logic req_stall;
   } ctrl_type;

   typedef struct packed {
      logic       fits;      // remaining days end inside this month
      logic       at_end;    // December of the last year
      logic       year_roll; // December: next month is January
      logic [4:0] day_sum;   // new day when fits
   } step_type;

   // Full Gregorian rule from year mod 4, century mod 4 and year mod 100
   function automatic logic is_leap(input logic [1:0] year_lo, input logic [1:0] cent_lo,
                                    input logic [6:0] rem);
      return (year_lo == 2'd0) && ((rem != 7'd0) || (cent_lo == 2'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/calendar_date_adder_unit.sv -----
`timescale 1ns / 1ps
// Calendar date adder: holds a Gregorian date and loads it or moves it forward.
// Request channel (req_*): req_mode 0 loads req_load_year/month/day, clamped to a
// valid date; req_mode 1 adds req_increment days. Valid/stall handshake: an item
// is taken on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): one item per request with the date after the
// operation; rsp_overflow is set when an add would pass 9999-12-31, in which
// case the date sticks at 9999-12-31.
// A load passes the divide-by-100 multiply, then the remainder and day clamp,
// before it answers. An add walks one month per cycle through a single
// add/compare unit before it answers.
// One item at a time: req_stall stays high from acceptance until the response
// is taken. While rsp_stall is high the response holds and nothing new enters.
// Synchronous reset sets the date to 0000-01-01 and leaves the block idle.
`include "calendar_date_adder_unit_macros.svh"

module calendar_date_adder_unit import cda_pkg::*; #(
   parameter int INCREMENT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_mode,
   input  logic [13:0]               req_load_year,
   input  logic [3:0]                req_load_month,
   input  logic [4:0]                req_load_day,
   input  logic [INCREMENT_BITS-1:0] req_increment,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [13:0]               rsp_cur_year,
   output logic [3:0]                rsp_cur_month,
   output logic [4:0]                rsp_cur_day,
   output logic                      rsp_overflow
);

   ctrl_type                  ctrl;
   step_type                  stat;
   logic                      walk_done;
   logic [INCREMENT_BITS-1:0] inc_next;

   logic [13:0]               year_ff,  year_in;
   logic [3:0]                month_ff, month_in;
   logic [4:0]                day_ff,   day_in;
   logic [6:0]                cent_ff,  cent_in;
   logic [6:0]                rem_ff,   rem_in;
   logic                      ovf_ff,   ovf_in;
   logic [INCREMENT_BITS-1:0] inc_ff,   inc_in;

   logic [13:0] ld_year;
   logic [3:0]  ld_month;
   logic [26:0] div_prod;
   logic [13:0] rem_full;
   logic [4:0]  ld_len;

   cda_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .rsp_stall (rsp_stall),
      .walk_done (walk_done),
      .ctrl      (ctrl)
   );

   cda_step #(
      .INCREMENT_BITS (INCREMENT_BITS)
   ) u_step (
      .year     (year_ff),
      .cent     (cent_ff),
      .rem      (rem_ff),
      .month    (month_ff),
      .day      (day_ff),
      .inc      (inc_ff),
      .stat     (stat),
      .inc_next (inc_next)
   );

   assign walk_done = ctrl.walk && (stat.fits || stat.at_end);

   assign ld_year  = (req_load_year > YEAR_MAX) ? YEAR_MAX : req_load_year;
   assign ld_month = (req_load_month < MONTH_JAN) ? MONTH_JAN :
                     (req_load_month > MONTH_DEC) ? MONTH_DEC : req_load_month;
   assign div_prod = 27'(year_ff) * DIV100_MULT;
   assign rem_full = year_ff - 14'(cent_ff) * CENT_YEARS;
   assign ld_len   = month_len(month_ff, is_leap(year_ff[1:0], cent_ff[1:0], rem_full[6:0]));

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      cent_in  = cent_ff;
      rem_in   = rem_ff;
      ovf_in   = ovf_ff;
      inc_in   = inc_ff;
      if (ctrl.accept_load) begin
         year_in  = ld_year;
         month_in = ld_month;
         day_in   = (req_load_day < DAY_FIRST) ? DAY_FIRST : req_load_day;
         ovf_in   = 1'b0;
      end
      if (ctrl.accept_add) begin
         inc_in = req_increment;
         ovf_in = 1'b0;
      end
      if (ctrl.load_div) begin
         cent_in = div_prod[DIV100_SHIFT+6:DIV100_SHIFT];
      end
      if (ctrl.load_fin) begin
         rem_in = rem_full[6:0];
         if (day_ff > ld_len) day_in = ld_len;
      end
      if (ctrl.walk) begin
         if (stat.fits) begin
            day_in = stat.day_sum;
         end else if (stat.at_end) begin
            month_in = MONTH_DEC;
            day_in   = DAY_DEC_END;
            ovf_in   = 1'b1;
         end else begin
            inc_in = inc_next;
            day_in = DAY_FIRST;
            if (stat.year_roll) begin
               month_in = MONTH_JAN;
               year_in  = year_ff + 14'd1;
               if (rem_ff == CENT_WRAP) begin
                  rem_in  = 7'd0;
                  cent_in = cent_ff + 7'd1;
               end else begin
                  rem_in = rem_ff + 7'd1;
               end
            end else begin
               month_in = month_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= '0;
         month_ff <= MONTH_JAN;
         day_ff   <= DAY_FIRST;
         cent_ff  <= '0;
         rem_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         cent_ff  <= cent_in;
         rem_ff   <= rem_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_ff <= inc_in;
   end

   assign req_stall     = ctrl.req_stall;
   assign rsp_valid     = ctrl.rsp_valid;
   assign rsp_cur_year  = year_ff;
   assign rsp_cur_month = month_ff;
   assign rsp_cur_day   = day_ff;
   assign rsp_overflow  = ovf_ff;

   // century split must track the year during the walk and while a response is valid
   `CDA_ASSERT_ALWAYS(a_year_split, !(ctrl.walk || ctrl.rsp_valid) || (year_ff == 14'(cent_ff) * CENT_YEARS + 14'(rem_ff)), "century split out of step with year")
   `CDA_ASSERT_ALWAYS(a_date_valid, !ctrl.rsp_valid || ((day_ff >= DAY_FIRST) && (day_ff <= month_len(month_ff, is_leap(year_ff[1:0], cent_ff[1:0], rem_ff))) && (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) && (year_ff <= YEAR_MAX)), "response date is not a valid date")
   `CDA_ASSERT_ALWAYS(a_ovf_date, !(ctrl.rsp_valid && ovf_ff) || ((year_ff == YEAR_MAX) && (month_ff == MONTH_DEC) && (day_ff == DAY_DEC_END)), "overflow without saturated date")
   `CDA_ASSERT_NEXT(a_load_ovf, ctrl.accept_load, !ovf_ff, "overflow left set by a load")

endmodule

// ----- rtl/cda_step.sv -----
`timescale 1ns / 1ps

// One month of the walk: adds the increment to the day, compares against the month length and reduces the increment.
module cda_step import cda_pkg::*; #(
   parameter int INCREMENT_BITS = 16
) (
   input  logic [13:0]               year,
   input  logic [6:0]                cent,
   input  logic [6:0]                rem,
   input  logic [3:0]                month,
   input  logic [4:0]                day,
   input  logic [INCREMENT_BITS-1:0] inc,
   output step_type                  stat,
   output logic [INCREMENT_BITS-1:0] inc_next
);

   localparam int SW = INCREMENT_BITS + 1;

   logic [4:0]    len;
   logic [SW-1:0] sum;
   logic [SW-1:0] used;

   assign len  = month_len(month, is_leap(year[1:0], cent[1:0], rem));
   assign sum  = SW'(inc) + SW'(day);
   // days consumed to reach the first of next month
   assign used = SW'(len) - SW'(day) + SW'(1);

   assign stat.fits      = (sum <= SW'(len));
   assign stat.year_roll = (month >= MONTH_DEC);
   assign stat.at_end    = stat.year_roll && (year >= YEAR_MAX);
   assign stat.day_sum   = sum[4:0];
   assign inc_next       = inc - used[INCREMENT_BITS-1:0];

endmodule

// ----- rtl/cda_seq.sv -----
`timescale 1ns / 1ps

module cda_seq import cda_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_mode,
   input  logic     rsp_stall,
   input  logic     walk_done,
   output ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = req_mode ? ST_WALK : ST_LOAD_DIV;
         end
         ST_LOAD_DIV: state_in = ST_LOAD_FIN;
         ST_LOAD_FIN: state_in = ST_RESP;
         ST_WALK: begin
            if (walk_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.accept_load = req_valid && !req_mode;
            ctrl.accept_add  = req_valid && req_mode;
         end
         ST_LOAD_DIV: begin
            ctrl.load_div  = 1'b1;
            ctrl.req_stall = 1'b1;
         end
         ST_LOAD_FIN: begin
            ctrl.load_fin  = 1'b1;
            ctrl.req_stall = 1'b1;
         end
         ST_WALK: begin
            ctrl.walk      = 1'b1;
            ctrl.req_stall = 1'b1;
         end
         ST_RESP: begin
            ctrl.rsp_valid = 1'b1;
            ctrl.req_stall = 1'b1;
         end
         default: ctrl.req_stall = 1'b1;
      endcase
   end

endmodule
